// ===== design/dbcs_pkg.sv =====
package dbcs_pkg;

  // Decimal digits that a saturated value can have.
  localparam int DEC_DIGITS = 7;
  localparam int MAX_DIGITS = 7;
  localparam int MAX_BLINKS = 128;

  localparam int VALUE_W = 24;
  localparam int UNIT_W  = 16;
  localparam int TIME_W  = 18;
  localparam int CNT_W   = 3;
  localparam int BLINK_W = 4;
  localparam int TOTAL_W = 9;

  localparam logic [UNIT_W-1:0] UNIT_RESET   = 16'd250;
  localparam logic              REPEAT_RESET = 1'b1;

  // Input kinds, carried on tuser.
  localparam logic [1:0] KIND_TICK   = 2'd0;
  localparam logic [1:0] KIND_START  = 2'd1;
  localparam logic [1:0] KIND_CANCEL = 2'd2;

  // Configuration register indexes.
  localparam logic CFG_BLINK_UNIT  = 1'b0;
  localparam logic CFG_REPEAT_MODE = 1'b1;

  // Largest value shown: 9999999, or all nines of MAX_DIGITS digits if smaller.
  function automatic longint sat_limit_calc(input int ndig);
    longint p;
    p = 1;
    for (int k = 0; k < ndig; k++) begin
      p = p * 10;
    end
    return ((p - 1) < 9999999) ? (p - 1) : 9999999;
  endfunction

  localparam logic [VALUE_W-1:0] SAT_LIMIT = VALUE_W'(sat_limit_calc(MAX_DIGITS));

  // Reciprocal multiply for x / 10, exact for every 24-bit x.
  localparam logic [VALUE_W-1:0] RECIP10 = 24'hCCCCCD;

  typedef logic [DEC_DIGITS-1:0][3:0] digits_t;

  // One item moving through the digit pipeline.
  typedef struct packed {
    logic [1:0]         kind;
    logic [VALUE_W-1:0] rem;
    digits_t            digits;
  } pipe_t;

  // Item handed to the sequencer: digits least significant first.
  typedef struct packed {
    logic [1:0]       kind;
    digits_t          digits;
    logic [CNT_W-1:0] cnt;
    logic             too_long;
  } item_t;

endpackage

// ===== design/dbcs_digit_pipe.sv =====
module dbcs_digit_pipe (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [1:0]                  in_kind,
  input  logic [dbcs_pkg::VALUE_W-1:0] in_value,
  output logic                        o_valid,
  input  logic                        o_ready,
  output dbcs_pkg::item_t             o_item
);

  localparam int NSTG = dbcs_pkg::DEC_DIGITS + 1;

  logic [NSTG-1:0]       vld_r;
  logic [NSTG-1:0]       rdy;
  dbcs_pkg::pipe_t       stg_r [NSTG];
  logic                  sum_vld_r;
  logic                  sum_rdy;
  dbcs_pkg::item_t       sum_r;
  dbcs_pkg::item_t       sum_nxt;
  logic [dbcs_pkg::VALUE_W-1:0] sat_value;

  assign sat_value = (in_value > dbcs_pkg::SAT_LIMIT) ? dbcs_pkg::SAT_LIMIT : in_value;

  assign sum_rdy  = !sum_vld_r || o_ready;
  assign in_ready = rdy[0];

  genvar k;
  generate
    for (k = 0; k < NSTG; k++) begin : g_stage
      if (k == NSTG - 1) begin : g_last
        assign rdy[k] = !vld_r[k] || sum_rdy;
      end else begin : g_mid
        assign rdy[k] = !vld_r[k] || rdy[k+1];
      end

      if (k == 0) begin : g_in
        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[k] <= 1'b0;
          end else if (rdy[k]) begin
            vld_r[k] <= in_valid;
          end
          if (rdy[k]) begin
            stg_r[k].kind   <= in_kind;
            stg_r[k].rem    <= sat_value;
            stg_r[k].digits <= '0;
          end
        end
      end else begin : g_peel
        // Each stage splits off one decimal digit of the remaining value.
        logic [2*dbcs_pkg::VALUE_W-1:0] prod;
        logic [dbcs_pkg::VALUE_W-1:0]   quot;
        logic [dbcs_pkg::VALUE_W-1:0]   rest;
        dbcs_pkg::pipe_t                peel;

        assign prod = {{dbcs_pkg::VALUE_W{1'b0}}, stg_r[k-1].rem} *
                      {{dbcs_pkg::VALUE_W{1'b0}}, dbcs_pkg::RECIP10};
        assign quot = dbcs_pkg::VALUE_W'(prod[2*dbcs_pkg::VALUE_W-1:27]);
        assign rest = stg_r[k-1].rem - ((quot << 3) + (quot << 1));

        always_comb begin
          peel             = stg_r[k-1];
          peel.rem         = quot;
          peel.digits[k-1] = rest[3:0];
        end

        always_ff @(posedge clk) begin
          if (!rst_n) begin
            vld_r[k] <= 1'b0;
          end else if (rdy[k]) begin
            vld_r[k] <= vld_r[k-1];
          end
          if (rdy[k]) begin
            stg_r[k] <= peel;
          end
        end
      end
    end
  endgenerate

  // Significant digit count and total blink count of the pattern.
  always_comb begin
    logic [dbcs_pkg::CNT_W-1:0]   cnt;
    logic [dbcs_pkg::TOTAL_W-1:0] total;
    cnt   = '0;
    total = '0;
    for (int i = 0; i < dbcs_pkg::DEC_DIGITS; i++) begin
      if (stg_r[NSTG-1].digits[i] != 4'd0) begin
        cnt = dbcs_pkg::CNT_W'(i + 1);
      end
    end
    for (int i = 0; i < dbcs_pkg::DEC_DIGITS; i++) begin
      if (i < int'(cnt)) begin
        total = total + ((stg_r[NSTG-1].digits[i] == 4'd0) ? dbcs_pkg::TOTAL_W'(10) :
                         dbcs_pkg::TOTAL_W'(stg_r[NSTG-1].digits[i]));
      end
    end
    sum_nxt.kind     = stg_r[NSTG-1].kind;
    sum_nxt.digits   = stg_r[NSTG-1].digits;
    sum_nxt.cnt      = cnt;
    sum_nxt.too_long = (total + dbcs_pkg::TOTAL_W'(1)) >
                       dbcs_pkg::TOTAL_W'(dbcs_pkg::MAX_BLINKS);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_vld_r <= 1'b0;
    end else if (sum_rdy) begin
      sum_vld_r <= vld_r[NSTG-1];
    end
    if (sum_rdy) begin
      sum_r <= sum_nxt;
    end
  end

  assign o_valid = sum_vld_r;
  assign o_item  = sum_r;

endmodule

// ===== design/dbcs_blink_fsm.sv =====
module dbcs_blink_fsm (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         i_valid,
  output logic                         i_ready,
  input  dbcs_pkg::item_t              i_item,
  input  logic [dbcs_pkg::UNIT_W-1:0]  blink_unit,
  input  logic                         repeat_mode,
  output logic                         o_valid,
  input  logic                         o_ready,
  output logic                         o_led_on,
  output logic                         o_running
);

  dbcs_pkg::digits_t              dig_r, dig_nxt;
  logic [dbcs_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [dbcs_pkg::CNT_W-1:0]     idx_r, idx_nxt;
  logic [dbcs_pkg::BLINK_W-1:0]   blink_r, blink_nxt;
  logic                           final_r, final_nxt;
  logic                           level_r, level_nxt;
  logic [dbcs_pkg::TIME_W-1:0]    time_r, time_nxt;
  logic                           active_r, active_nxt;
  logic                           out_vld_r;
  logic                           take;

  logic [dbcs_pkg::TIME_W-1:0]    unit1;
  logic [dbcs_pkg::TIME_W-1:0]    unit2;
  logic [dbcs_pkg::CNT_W-1:0]     pos;
  logic [3:0]                     cur_digit;
  logic [4:0]                     cur_blinks;
  logic [dbcs_pkg::TIME_W-1:0]    time_dec;

  assign i_ready = !out_vld_r || o_ready;
  assign take    = i_valid && i_ready;

  assign unit1 = (blink_unit == '0) ? dbcs_pkg::TIME_W'(1) : dbcs_pkg::TIME_W'(blink_unit);
  assign unit2 = unit1 << 1;

  // Digits are kept least significant first; the pattern walks from the top.
  assign pos        = cnt_r - dbcs_pkg::CNT_W'(1) - idx_r;
  assign cur_digit  = (idx_r < cnt_r) ? dig_r[pos] : 4'd0;
  assign cur_blinks = (cur_digit == 4'd0) ? 5'd10 : {1'b0, cur_digit};
  assign time_dec   = (time_r != '0) ? time_r - dbcs_pkg::TIME_W'(1) : time_r;

  always_comb begin
    logic [4:0] bnext;
    dig_nxt    = dig_r;
    cnt_nxt    = cnt_r;
    idx_nxt    = idx_r;
    blink_nxt  = blink_r;
    final_nxt  = final_r;
    level_nxt  = level_r;
    time_nxt   = time_r;
    active_nxt = active_r;
    bnext      = {1'b0, blink_r} + 5'd1;
    unique case (i_item.kind)
      dbcs_pkg::KIND_TICK: begin
        if (active_r) begin
          time_nxt = time_dec;
          if (time_dec == '0) begin
            if (level_r) begin
              level_nxt = 1'b0;
              if (final_r) begin
                if (!repeat_mode) begin
                  active_nxt = 1'b0;
                  time_nxt   = '0;
                  idx_nxt    = '0;
                  blink_nxt  = '0;
                  final_nxt  = 1'b0;
                end else begin
                  time_nxt = unit2;
                end
              end else if (bnext >= cur_blinks) begin
                time_nxt = unit2;
              end else begin
                time_nxt = unit1;
              end
            end else begin
              if (final_r) begin
                idx_nxt   = '0;
                blink_nxt = '0;
                final_nxt = (cnt_r == '0);
              end else if (bnext >= cur_blinks) begin
                blink_nxt = '0;
                idx_nxt   = idx_r + dbcs_pkg::CNT_W'(1);
                if ({1'b0, idx_r} + 4'd1 >= {1'b0, cnt_r}) begin
                  final_nxt = 1'b1;
                end
              end else begin
                blink_nxt = bnext[dbcs_pkg::BLINK_W-1:0];
              end
              level_nxt = 1'b1;
              time_nxt  = final_nxt ? unit2 : unit1;
            end
          end
        end
      end
      dbcs_pkg::KIND_START: begin
        dig_nxt   = i_item.digits;
        cnt_nxt   = i_item.cnt;
        idx_nxt   = '0;
        blink_nxt = '0;
        if (i_item.too_long) begin
          active_nxt = 1'b0;
          level_nxt  = 1'b0;
          time_nxt   = '0;
          final_nxt  = 1'b0;
        end else begin
          active_nxt = 1'b1;
          level_nxt  = 1'b1;
          final_nxt  = (i_item.cnt == '0);
          time_nxt   = (i_item.cnt == '0) ? unit2 : unit1;
        end
      end
      dbcs_pkg::KIND_CANCEL: begin
        active_nxt = 1'b0;
        level_nxt  = 1'b0;
        time_nxt   = '0;
        idx_nxt    = '0;
        blink_nxt  = '0;
        final_nxt  = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dig_r     <= '0;
      cnt_r     <= '0;
      idx_r     <= '0;
      blink_r   <= '0;
      final_r   <= 1'b0;
      level_r   <= 1'b0;
      time_r    <= '0;
      active_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (take) begin
        dig_r    <= dig_nxt;
        cnt_r    <= cnt_nxt;
        idx_r    <= idx_nxt;
        blink_r  <= blink_nxt;
        final_r  <= final_nxt;
        level_r  <= level_nxt;
        time_r   <= time_nxt;
        active_r <= active_nxt;
      end
      if (take) begin
        out_vld_r <= 1'b1;
      end else if (o_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // The state registers only move when a transaction enters the result slot,
  // so they hold exactly the fields of the waiting result.
  assign o_valid   = out_vld_r;
  assign o_led_on  = level_r;
  assign o_running = active_r;

  a_level_needs_active: assert property (@(posedge clk) disable iff (!rst_n)
    level_r |-> active_r) else $error("output on while no pattern is active");

  a_time_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (time_r != '0)) else $error("active pattern with no time left");

  a_index_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (active_r && !final_r) |-> (idx_r < cnt_r)) else $error("digit index past count");

  a_blink_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    blink_r < 4'd10) else $error("blink count within digit out of range");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !o_ready) |=> ($stable(level_r) && $stable(active_r)))
    else $error("pattern state moved while result stalled");

endmodule

// ===== design/decimal_blink_code_sequencer.sv =====
// Path of an accepted input transaction, register by register: input register,
// seven digit-split stages, count stage, sequencer state.
// Throughput: one transaction per cycle; the pipeline keeps filling while a
// result waits, and stalls only when every stage is occupied.
// Reset (rst_n low, synchronous): pipeline emptied, pattern idle with output
// off, blink_unit = 250, repeat_mode = 1.
module decimal_blink_code_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // [23:0] value
  input  logic [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [0] led_on, [1] running, [7:2] zero
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [15:0] cfg_wdata
);

  logic [dbcs_pkg::UNIT_W-1:0] unit_r;
  logic                        repeat_r;
  logic                        mid_valid;
  logic                        mid_ready;
  dbcs_pkg::item_t             mid_item;
  logic                        led_on;
  logic                        running;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      unit_r   <= dbcs_pkg::UNIT_RESET;
      repeat_r <= dbcs_pkg::REPEAT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        dbcs_pkg::CFG_BLINK_UNIT:  unit_r   <= cfg_wdata;
        dbcs_pkg::CFG_REPEAT_MODE: repeat_r <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  dbcs_digit_pipe u_digit_pipe (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .in_kind  (in_tuser),
    .in_value (in_tdata),
    .o_valid  (mid_valid),
    .o_ready  (mid_ready),
    .o_item   (mid_item)
  );

  dbcs_blink_fsm u_blink_fsm (
    .clk         (clk),
    .rst_n       (rst_n),
    .i_valid     (mid_valid),
    .i_ready     (mid_ready),
    .i_item      (mid_item),
    .blink_unit  (unit_r),
    .repeat_mode (repeat_r),
    .o_valid     (out_tvalid),
    .o_ready     (out_tready),
    .o_led_on    (led_on),
    .o_running   (running)
  );

  assign out_tdata = {6'b0, running, led_on};

endmodule

// ===== bench/dbcs_checker.sv =====
`timescale 1ns / 100ps

module dbcs_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  input  logic                         in_tready,
  input  logic [dbcs_pkg::VALUE_W-1:0] in_tdata,   // [23:0] value
  input  logic [1:0]                   in_tuser,   // [1:0] kind
  input  logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic [7:0]                   out_tdata,  // [0] led_on, [1] running, [7:2] zero
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [dbcs_pkg::UNIT_W-1:0]  cfg_wdata,
  output int                           mismatches,
  output int                           pending
);

  typedef struct packed {
    logic led_on;
    logic running;
  } lamp_t;

  lamp_t lamp_q[$];

  // Configuration as the block should hold it.
  logic [dbcs_pkg::UNIT_W-1:0]  unit_len;
  logic                         repeat_on;

  // Pattern state.
  logic [3:0]                   shown_digits[dbcs_pkg::MAX_DIGITS];
  logic [dbcs_pkg::CNT_W-1:0]   shown_count;
  logic [dbcs_pkg::CNT_W-1:0]   cur_digit;
  logic [dbcs_pkg::BLINK_W-1:0] cur_blink;
  logic                         on_closing;
  logic                         lamp;
  logic [dbcs_pkg::TIME_W-1:0]  remaining;
  logic                         playing;

  initial begin
    mismatches = 0;
    pending = 0;
  end

  function automatic logic [dbcs_pkg::TIME_W-1:0] unit_ticks();
    return (unit_len == '0) ? dbcs_pkg::TIME_W'(1) : dbcs_pkg::TIME_W'(unit_len);
  endfunction

  // A zero digit is shown as ten blinks.
  function automatic logic [4:0] blinks_for(input logic [dbcs_pkg::CNT_W-1:0] idx);
    logic [3:0] d;
    d = (int'(idx) < dbcs_pkg::MAX_DIGITS) ? shown_digits[idx] : 4'd0;
    return (d == 4'd0) ? 5'd10 : 5'(d);
  endfunction

  function automatic void halt_pattern();
    playing = 1'b0;
    lamp = 1'b0;
    remaining = '0;
    cur_digit = '0;
    cur_blink = '0;
    on_closing = 1'b0;
  endfunction

  function automatic void load_value(input logic [dbcs_pkg::VALUE_W-1:0] value);
    logic [dbcs_pkg::VALUE_W-1:0] v;
    logic [3:0]                   tmp[8];
    int                           n;
    int                           total;
    v = (value > dbcs_pkg::SAT_LIMIT) ? dbcs_pkg::SAT_LIMIT : value;
    n = 0;
    while (v > 0 && n < 8) begin
      tmp[n] = 4'(v % dbcs_pkg::VALUE_W'(10));
      v = v / dbcs_pkg::VALUE_W'(10);
      n++;
    end
    for (int k = 0; k < dbcs_pkg::MAX_DIGITS; k++) begin
      shown_digits[k] = 4'd0;
    end
    for (int k = 0; k < n && k < dbcs_pkg::MAX_DIGITS; k++) begin
      shown_digits[k] = tmp[n - 1 - k];
    end
    shown_count = dbcs_pkg::CNT_W'((n < dbcs_pkg::MAX_DIGITS) ? n : dbcs_pkg::MAX_DIGITS);
    total = 0;
    for (int k = 0; k < int'(shown_count); k++) begin
      total += int'(blinks_for(dbcs_pkg::CNT_W'(k)));
    end
    if (total + 1 > dbcs_pkg::MAX_BLINKS) begin
      halt_pattern();
      return;
    end
    cur_digit = '0;
    cur_blink = '0;
    on_closing = (shown_count == '0);
    playing = 1'b1;
    lamp = 1'b1;
    remaining = on_closing ? dbcs_pkg::TIME_W'(2 * unit_ticks()) : unit_ticks();
  endfunction

  function automatic void phase_over();
    logic [dbcs_pkg::TIME_W-1:0] u;
    u = unit_ticks();
    if (lamp) begin
      lamp = 1'b0;
      if (on_closing) begin
        // A single play ends right after the long blink's on phase.
        if (!repeat_on) begin
          halt_pattern();
          return;
        end
        remaining = dbcs_pkg::TIME_W'(2 * u);
      end else if (5'(cur_blink) + 5'd1 >= blinks_for(cur_digit)) begin
        remaining = dbcs_pkg::TIME_W'(2 * u);
      end else begin
        remaining = u;
      end
      return;
    end
    if (on_closing) begin
      cur_digit = '0;
      cur_blink = '0;
      on_closing = (shown_count == '0);
    end else begin
      cur_blink++;
      if (5'(cur_blink) >= blinks_for(cur_digit)) begin
        cur_blink = '0;
        cur_digit++;
        if (cur_digit >= shown_count) begin
          on_closing = 1'b1;
        end
      end
    end
    lamp = 1'b1;
    remaining = on_closing ? dbcs_pkg::TIME_W'(2 * u) : u;
  endfunction

  function automatic void apply_item(input logic [1:0] kind,
                                     input logic [dbcs_pkg::VALUE_W-1:0] value);
    case (kind)
      dbcs_pkg::KIND_TICK: begin
        if (playing) begin
          if (remaining > 0) begin
            remaining--;
          end
          if (remaining == 0) begin
            phase_over();
          end
        end
      end
      dbcs_pkg::KIND_START: begin
        load_value(value);
      end
      dbcs_pkg::KIND_CANCEL: begin
        halt_pattern();
      end
      default: begin
      end
    endcase
  endfunction

  function automatic void report(input string what, input lamp_t want, input lamp_t got);
    mismatches++;
    if (mismatches <= 10) begin
      $display("[%0t] %s: expected led_on=%0b running=%0b, got led_on=%0b running=%0b",
               $time, what, want.led_on, want.running, got.led_on, got.running);
    end
  endfunction

  always @(posedge clk) begin : watch
    lamp_t want;
    lamp_t got;
    if (!rst_n) begin
      unit_len = dbcs_pkg::UNIT_RESET;
      repeat_on = dbcs_pkg::REPEAT_RESET;
      for (int k = 0; k < dbcs_pkg::MAX_DIGITS; k++) begin
        shown_digits[k] = 4'd0;
      end
      shown_count = '0;
      halt_pattern();
      lamp_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          dbcs_pkg::CFG_BLINK_UNIT:  unit_len = cfg_wdata;
          dbcs_pkg::CFG_REPEAT_MODE: repeat_on = cfg_wdata[0];
          default: begin
          end
        endcase
      end
      if (in_tvalid && in_tready) begin
        apply_item(in_tuser, in_tdata);
        want.led_on = lamp;
        want.running = playing;
        lamp_q.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.led_on = out_tdata[0];
        got.running = out_tdata[1];
        if (lamp_q.size() == 0) begin
          want = '0;
          report("result with no transaction outstanding", want, got);
        end else begin
          want = lamp_q.pop_front();
          if (want.led_on !== got.led_on || want.running !== got.running) begin
            report("result mismatch", want, got);
          end
        end
      end
    end
    pending = lamp_q.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 100ps

module tb;

  localparam logic [1:0] KIND_SPARE   = 2'd3;
  localparam int         LIMIT_CYCLES = 400000;
  localparam int         DRAIN_CYCLES = 12;
  localparam int         STALL_AT     = 600;
  localparam int         LONG_STALL   = 300;

  logic                         clk;
  logic                         rst_n;
  logic                         in_tvalid;
  logic                         in_tready;
  logic [dbcs_pkg::VALUE_W-1:0] in_tdata;   // [23:0] value
  logic [1:0]                   in_tuser;   // [1:0] kind
  logic                         out_tvalid;
  logic                         out_tready;
  logic [7:0]                   out_tdata;  // [0] led_on, [1] running, [7:2] zero
  logic                         cfg_we;
  logic                         cfg_addr;
  logic [dbcs_pkg::UNIT_W-1:0]  cfg_wdata;

  int mismatches;
  int pending;
  int cycles;
  int send_calm;
  int recv_calm;

  decimal_blink_code_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  dbcs_checker chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .mismatches(mismatches),
    .pending   (pending)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("decimal_blink_code_sequencer verification failed");
      $finish;
    end
  end

  // Wait length before a transaction; now and then a calm stretch with no waits.
  function automatic int draw_gap(ref int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      calm = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 18);
  endfunction

  function automatic logic [dbcs_pkg::VALUE_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return dbcs_pkg::VALUE_W'($urandom_range(0, 99));
      5, 6:          return dbcs_pkg::VALUE_W'($urandom_range(0, 9999));
      7:             return dbcs_pkg::VALUE_W'($urandom_range(0, 9999999));
      8:             return dbcs_pkg::VALUE_W'($urandom);
      default:       return '0;
    endcase
  endfunction

  // Called and returns at a falling edge.
  task automatic send_item(input logic [1:0] kind,
                           input logic [dbcs_pkg::VALUE_W-1:0] value);
    int gap;
    gap = draw_gap(send_calm);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic settle();
    in_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_config(input logic [dbcs_pkg::UNIT_W-1:0] unit, input logic rep);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= dbcs_pkg::CFG_BLINK_UNIT;
    cfg_wdata <= unit;
    @(negedge clk);
    cfg_addr  <= dbcs_pkg::CFG_REPEAT_MODE;
    cfg_wdata <= dbcs_pkg::UNIT_W'(rep);
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Start a pattern, then mostly ticks, with the odd cancel, restart or unused kind.
  task automatic run_phase(input int count);
    int         sent;
    int         run;
    int         r;
    logic [1:0] kind;
    sent = 0;
    while (sent < count) begin
      send_item(dbcs_pkg::KIND_START, pick_value());
      sent++;
      run = $urandom_range(1, 120);
      for (int i = 0; i < run && sent < count; i++) begin
        r = $urandom_range(0, 59);
        kind = (r == 0) ? dbcs_pkg::KIND_CANCEL : (r == 1) ? KIND_SPARE :
               (r == 2) ? dbcs_pkg::KIND_START : dbcs_pkg::KIND_TICK;
        send_item(kind, (kind == dbcs_pkg::KIND_START) ? pick_value() :
                        dbcs_pkg::VALUE_W'($urandom));
        sent++;
      end
    end
  endtask

  // Result side: random stalls, plus one long hold-off so the input backs up.
  initial begin : receiver
    int gap;
    int delivered;
    out_tready = 1'b0;
    delivered = 0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      gap = (delivered == STALL_AT) ? LONG_STALL : draw_gap(recv_calm);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      delivered++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = dbcs_pkg::KIND_TICK;
    cfg_we    = 1'b0;
    cfg_addr  = dbcs_pkg::CFG_BLINK_UNIT;
    cfg_wdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, first at the reset settings.
    send_item(dbcs_pkg::KIND_START, 24'd3);
    send_item(dbcs_pkg::KIND_TICK, '0);
    send_item(dbcs_pkg::KIND_CANCEL, '0);
    send_item(dbcs_pkg::KIND_TICK, '0);
    set_config(16'd1, 1'b1);
    // Zero shows only the long blink, repeated.
    send_item(dbcs_pkg::KIND_START, '0);
    for (int i = 0; i < 5; i++) send_item(dbcs_pkg::KIND_TICK, '0);
    // A zero digit gives ten blinks.
    send_item(dbcs_pkg::KIND_START, 24'd10);
    for (int i = 0; i < 4; i++) send_item(dbcs_pkg::KIND_TICK, '0);
    send_item(dbcs_pkg::KIND_START, 24'hFFFFFF);
    send_item(dbcs_pkg::KIND_TICK, '0);
    send_item(KIND_SPARE, 24'hFFFFFF);
    send_item(dbcs_pkg::KIND_TICK, 24'hFFFFFF);
    send_item(dbcs_pkg::KIND_CANCEL, '0);
    send_item(dbcs_pkg::KIND_CANCEL, '0);
    send_item(dbcs_pkg::KIND_START, 24'd9999999);
    send_item(dbcs_pkg::KIND_START, 24'd8);
    send_item(dbcs_pkg::KIND_TICK, '0);

    set_config(16'd0, 1'b1);
    run_phase(200);
    set_config(16'd1, 1'b0);
    run_phase(250);
    set_config(16'd2, 1'b1);
    run_phase(250);
    set_config(16'd3, 1'b0);
    run_phase(200);
    set_config(16'hFFFF, 1'b0);
    run_phase(60);
    set_config(16'd1, 1'b1);
    run_phase(240);

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("decimal_blink_code_sequencer verification clean");
    end else begin
      $display("decimal_blink_code_sequencer verification failed");
    end
    $finish;
  end

endmodule

// ===== decimal_blink_code_sequencer.f =====
design/dbcs_pkg.sv
design/dbcs_digit_pipe.sv
design/dbcs_blink_fsm.sv
design/decimal_blink_code_sequencer.sv
bench/dbcs_checker.sv
bench/tb.sv
